>>> hw/rtl/fqd_pkg.sv
package fqd_pkg;

    // Operation codes carried in the kind field of a command.
    localparam logic [2:0] KIND_PUSH  = 3'd0;
    localparam logic [2:0] KIND_POP   = 3'd1;
    localparam logic [2:0] KIND_TAKE  = 3'd2;
    localparam logic [2:0] KIND_DROP  = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    // Key frame types; every other type may be dropped.
    localparam logic [1:0] TYPE_IDR = 2'd0;
    localparam logic [1:0] TYPE_I   = 2'd1;

    // Number of descriptor slots in the queue.
    localparam int QUEUE_DEPTH = 16;

    // Width of the reported occupancy field, wide enough for a full queue.
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame_handle;
        logic [1:0]  pic_type;
    } cmd_t;

    typedef struct packed {
        logic             ok;
        logic [31:0]      out_handle;
        logic [1:0]       out_type;
        logic             released;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [1:0]  ftype;
    } entry_t;

endpackage

>>> hw/rtl/frame_queue_drop_non_key_unit.sv
// Frame descriptor queue with selective drop of non-key frames.
//
// Commands enter on the cmd channel (cmd_valid / cmd_stall / cmd) and each
// command produces exactly one response transaction on the rsp channel
// (rsp_valid / rsp_stall / rsp). A command is taken when cmd_valid is high
// and cmd_stall is low; cmd_stall is high while a command is in progress.
// The descriptors live in one single-port-write, single-port-read memory
// with a registered read, driven by a small sequencer.
//
// A push, clear or unused kind goes straight to S_OUT; a pop or take passes
// through S_TAKE first, where the head entry read from memory is registered.
// A drop reads one entry per cycle while it searches from the head (S_SCAN)
// and then moves one later entry per cycle to close the gap (S_SHIFT) before
// S_OUT. The response is loaded in S_OUT, and the next command is taken only
// once the sequencer is back in S_IDLE.
//
// The response sits in an output register. A new command is accepted while
// a response still waits; if the receiver stalls, the next response is held
// in the sequencer until the output register frees. Reset empties the queue
// (head and count to zero); the memory contents are not cleared.
module frame_queue_drop_non_key_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  fqd_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fqd_pkg::rsp_t rsp
);

    localparam int QUEUE_DEPTH = fqd_pkg::QUEUE_DEPTH;
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = fqd_pkg::OCC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SCAN,
        S_SHIFT,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic              rel_reg;
    fqd_pkg::rsp_t     res_reg;
    fqd_pkg::rsp_t     res_next;
    fqd_pkg::rsp_t     rsp_reg;
    fqd_pkg::rsp_t     rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    fqd_pkg::entry_t   mem [QUEUE_DEPTH];
    fqd_pkg::entry_t   rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    fqd_pkg::entry_t   wr_data;

    logic [CW-1:0]     idx_plus1;
    logic [CW-1:0]     idx_plus2;
    logic              full;
    logic              accept;
    logic              out_free;

    // Physical slot of the entry at a given distance from the head.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        begin
            sum = (CW+1)'(head) + (CW+1)'(off);
            if (sum >= (CW+1)'(QUEUE_DEPTH))
            begin
                sum = sum - (CW+1)'(QUEUE_DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    assign idx_plus1 = idx_reg + CW'(1);
    assign idx_plus2 = idx_reg + CW'(2);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign accept    = (state_reg == S_IDLE) && cmd_valid;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Memory port control. The read address runs one entry ahead of the
    // entry being examined so the search and the shift move one per cycle.
    always_comb
    begin
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, count_reg);
        wr_data.handle = cmd.frame_handle;
        wr_data.ftype  = cmd.pic_type;
        case (state_reg)
            S_IDLE:
            begin
                wr_en = accept && (cmd.kind == fqd_pkg::KIND_PUSH) && !full;
            end
            S_SCAN:
            begin
                rd_addr = slot_of(head_reg, idx_plus1);
            end
            S_SHIFT:
            begin
                rd_addr = slot_of(head_reg, idx_plus2);
                wr_en   = (idx_plus1 < count_reg);
                wr_addr = slot_of(head_reg, idx_reg);
                wr_data = rd_data_reg;
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    // Next values of the pending result, the output register and its valid.
    always_comb
    begin
        res_next = res_reg;
        rsp_next = res_reg;
        rsp_next.occupancy = fqd_pkg::OCC_W'(count_reg);
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                res_next = '0;
                if ((cmd.kind == fqd_pkg::KIND_CLEAR) ||
                    ((cmd.kind == fqd_pkg::KIND_PUSH) && !full))
                begin
                    res_next.ok = 1'b1;
                end
            end
            S_TAKE:
            begin
                res_next.ok         = 1'b1;
                res_next.out_handle = rd_data_reg.handle;
                res_next.out_type   = rd_data_reg.ftype;
                res_next.released   = rel_reg;
            end
            S_SCAN:
            begin
                // The entry at distance idx from the head is in rd_data_reg.
                if (rd_data_reg.ftype != fqd_pkg::TYPE_IDR &&
                    rd_data_reg.ftype != fqd_pkg::TYPE_I)
                begin
                    res_next.ok         = 1'b1;
                    res_next.out_handle = rd_data_reg.handle;
                    res_next.out_type   = rd_data_reg.ftype;
                    res_next.released   = 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rel_reg       <= 1'b0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            res_reg       <= res_next;
            rsp_valid_reg <= rsp_valid_next;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        idx_reg <= '0;
                        rel_reg <= (cmd.kind == fqd_pkg::KIND_POP);
                        case (cmd.kind)
                            fqd_pkg::KIND_PUSH:
                            begin
                                if (!full)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                state_reg <= S_OUT;
                            end
                            fqd_pkg::KIND_POP, fqd_pkg::KIND_TAKE:
                            begin
                                state_reg <= (count_reg != '0) ? S_TAKE : S_OUT;
                            end
                            fqd_pkg::KIND_DROP:
                            begin
                                state_reg <= (count_reg != '0) ? S_SCAN : S_OUT;
                            end
                            fqd_pkg::KIND_CLEAR:
                            begin
                                head_reg  <= '0;
                                count_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_TAKE:
                begin
                    head_reg  <= slot_of(head_reg, CW'(1));
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_OUT;
                end
                S_SCAN:
                begin
                    if (rd_data_reg.ftype != fqd_pkg::TYPE_IDR &&
                        rd_data_reg.ftype != fqd_pkg::TYPE_I)
                    begin
                        state_reg <= S_SHIFT;
                    end
                    else if (idx_plus1 < count_reg)
                    begin
                        idx_reg <= idx_plus1;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SHIFT:
                begin
                    // Each cycle the next later entry moves into the gap.
                    if (idx_plus1 < count_reg)
                    begin
                        idx_reg <= idx_plus1;
                    end
                    else
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= rsp_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
